// ----- hw/rtl/sled_pkg.sv -----
package sled_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int LEN_W     = 6;
    localparam int ERR_W     = 2;
    localparam int TALLY_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_PAYLOAD_DEF   = 32;
    localparam int LINE_CAPACITY_DEF = 32;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = BYTE_W'(170);
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = BYTE_W'(85);
    localparam logic [BYTE_W-1:0] CHAR_CR          = BYTE_W'(13);
    localparam logic [BYTE_W-1:0] CHAR_LF          = BYTE_W'(10);

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME_HDR = 3'd0,
        KIND_PAYLOAD   = 3'd1,
        KIND_LINE_HDR  = 3'd2,
        KIND_LINE_CHAR = 3'd3,
        KIND_FRAME_ERR = 3'd4,
        KIND_LINE_OVF  = 3'd5
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_LENGTH     = 2'd0,
        ERR_CHECKSUM   = 2'd1,
        ERR_END_MARKER = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        ST_WAIT,
        ST_CMD,
        ST_LEN,
        ST_DATA,
        ST_SUM,
        ST_END,
        ST_FRM_RD,
        ST_FRM_WR,
        ST_LIN_RD,
        ST_LIN_WR
    } t_state;

    typedef struct packed {
        logic  store_cmd;
        logic  load_len;
        logic  take_data;
        logic  clear_frame;
        logic  line_push;
        logic  line_drop;
        logic  emit_frame;
        logic  emit_line;
        logic  read_pay;
        logic  read_line;
        logic  emit_step;
        logic  out_load;
        t_kind out_kind;
        t_err  out_err;
        logic  out_last;
        logic  inc_good;
        logic  inc_bad;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic is_end;
        logic is_cr;
        logic is_lf;
        logic len_bad;
        logic len_zero;
        logic xor_ok;
        logic pay_done;
        logic frame_empty;
        logic line_full;
        logic line_empty;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/sled_ram.sv -----
module sled_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sled_dp.sv -----
module sled_dp #(
    parameter int MAX_PAYLOAD   = sled_pkg::MAX_PAYLOAD_DEF,
    parameter int LINE_CAPACITY = sled_pkg::LINE_CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sled_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sled_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic [sled_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic                              i_res_stall,
    input  sled_pkg::t_dp_cmd                 i_cmd,
    output sled_pkg::t_dp_stat                o_stat,
    output logic                              o_res_valid,
    output logic [sled_pkg::KIND_W-1:0]       o_kind,
    output logic [sled_pkg::BYTE_W-1:0]       o_command,
    output logic [sled_pkg::LEN_W-1:0]        o_length,
    output logic [sled_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [sled_pkg::ERR_W-1:0]        o_error_code,
    output logic                              o_last,
    output logic [sled_pkg::TALLY_W-1:0]      o_good_frames,
    output logic [sled_pkg::TALLY_W-1:0]      o_bad_frames
);

    localparam int PAY_AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LINE_DEPTH = LINE_CAPACITY - 1;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int FILL_W     = $clog2(LINE_CAPACITY);

    logic [sled_pkg::BYTE_W-1:0]  r_start_marker;
    logic [sled_pkg::BYTE_W-1:0]  r_end_marker;
    logic [sled_pkg::BYTE_W-1:0]  r_cmd;
    logic [sled_pkg::LEN_W-1:0]   r_len;
    logic [sled_pkg::LEN_W-1:0]   r_pos;
    logic [sled_pkg::BYTE_W-1:0]  r_xor;
    logic [FILL_W-1:0]            r_line_fill;
    logic [sled_pkg::TALLY_W-1:0] r_good;
    logic [sled_pkg::TALLY_W-1:0] r_bad;
    logic [sled_pkg::LEN_W-1:0]   r_emit_len;
    logic [sled_pkg::LEN_W-1:0]   r_emit_idx;

    logic                         r_out_valid;
    sled_pkg::t_kind              r_out_kind;
    logic [sled_pkg::BYTE_W-1:0]  r_out_cmd;
    logic [sled_pkg::LEN_W-1:0]   r_out_len;
    logic [sled_pkg::BYTE_W-1:0]  r_out_data;
    logic [sled_pkg::ERR_W-1:0]   r_out_err;
    logic                         r_out_last;

    logic [sled_pkg::BYTE_W-1:0]  pay_rdata;
    logic [sled_pkg::BYTE_W-1:0]  line_rdata;
    logic [sled_pkg::LEN_W-1:0]   pos_inc;
    logic [sled_pkg::LEN_W-1:0]   idx_inc;
    logic                         out_free;

    assign pos_inc  = r_pos + sled_pkg::LEN_W'(1);
    assign idx_inc  = r_emit_idx + sled_pkg::LEN_W'(1);
    assign out_free = !r_out_valid || !i_res_stall;

    sled_ram #(
        .WIDTH  (sled_pkg::BYTE_W),
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (PAY_AW)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_data),
        .i_waddr (r_pos[PAY_AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.read_pay),
        .i_raddr (r_emit_idx[PAY_AW-1:0]),
        .o_rdata (pay_rdata)
    );

    sled_ram #(
        .WIDTH  (sled_pkg::BYTE_W),
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (LINE_AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.line_push),
        .i_waddr (r_line_fill[LINE_AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.read_line),
        .i_raddr (r_emit_idx[LINE_AW-1:0]),
        .o_rdata (line_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= sled_pkg::START_MARKER_RST;
            r_end_marker   <= sled_pkg::END_MARKER_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sled_pkg::CFG_START_MARKER) begin
                r_start_marker <= i_cfg_data;
            end
            if (i_cfg_idx == sled_pkg::CFG_END_MARKER) begin
                r_end_marker <= i_cfg_data;
            end
        end
    end

    // Frame parse state and tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_xor       <= '0;
            r_line_fill <= '0;
            r_good      <= '0;
            r_bad       <= '0;
        end else begin
            if (i_cmd.store_cmd) begin
                r_cmd <= i_rx_byte;
            end
            if (i_cmd.load_len) begin
                r_len <= i_rx_byte[sled_pkg::LEN_W-1:0];
                r_pos <= '0;
                r_xor <= r_cmd ^ i_rx_byte;
            end
            if (i_cmd.take_data) begin
                r_xor <= r_xor ^ i_rx_byte;
                r_pos <= pos_inc;
            end
            if (i_cmd.clear_frame) begin
                r_cmd <= '0;
                r_len <= '0;
                r_pos <= '0;
                r_xor <= '0;
            end
            if (i_cmd.line_push) begin
                r_line_fill <= r_line_fill + FILL_W'(1);
            end
            if (i_cmd.line_drop || i_cmd.emit_line) begin
                r_line_fill <= '0;
            end
            if (i_cmd.inc_good) begin
                r_good <= r_good + sled_pkg::TALLY_W'(1);
            end
            if (i_cmd.inc_bad) begin
                r_bad <= r_bad + sled_pkg::TALLY_W'(1);
            end
        end
    end

    // Burst emission counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_frame) begin
            r_emit_len <= r_len;
            r_emit_idx <= '0;
        end else if (i_cmd.emit_line) begin
            r_emit_len <= sled_pkg::LEN_W'(r_line_fill);
            r_emit_idx <= '0;
        end else if (i_cmd.emit_step) begin
            r_emit_idx <= idx_inc;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_last <= i_cmd.out_last;
            r_out_cmd  <= '0;
            r_out_len  <= '0;
            r_out_data <= '0;
            r_out_err  <= '0;
            case (i_cmd.out_kind)
                sled_pkg::KIND_FRAME_HDR: begin
                    r_out_cmd  <= r_cmd;
                    r_out_len  <= r_len;
                    r_out_data <= r_xor;
                end
                sled_pkg::KIND_PAYLOAD: begin
                    r_out_data <= pay_rdata;
                end
                sled_pkg::KIND_LINE_HDR: begin
                    r_out_len <= sled_pkg::LEN_W'(r_line_fill);
                end
                sled_pkg::KIND_LINE_CHAR: begin
                    r_out_data <= line_rdata;
                end
                sled_pkg::KIND_FRAME_ERR: begin
                    r_out_err <= i_cmd.out_err;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.is_start    = (i_rx_byte == r_start_marker);
        o_stat.is_end      = (i_rx_byte == r_end_marker);
        o_stat.is_cr       = (i_rx_byte == sled_pkg::CHAR_CR);
        o_stat.is_lf       = (i_rx_byte == sled_pkg::CHAR_LF);
        o_stat.len_bad     = (i_rx_byte > sled_pkg::BYTE_W'(MAX_PAYLOAD));
        o_stat.len_zero    = (i_rx_byte == '0);
        o_stat.xor_ok      = (i_rx_byte == r_xor);
        o_stat.pay_done    = (pos_inc >= r_len);
        o_stat.frame_empty = (r_len == '0);
        o_stat.line_full   = (r_line_fill == FILL_W'(LINE_CAPACITY - 1));
        o_stat.line_empty  = (r_line_fill == '0);
        o_stat.emit_last   = (idx_inc == r_emit_len);
        o_stat.out_free    = out_free;
    end

    assign o_res_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_command     = r_out_cmd;
    assign o_length      = r_out_len;
    assign o_data_byte   = r_out_data;
    assign o_error_code  = r_out_err;
    assign o_last        = r_out_last;
    assign o_good_frames = r_good;
    assign o_bad_frames  = r_bad;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_fill <= FILL_W'(LINE_CAPACITY - 1))
        else $error("line fill beyond capacity");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("payload position past frame length");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten while held");

endmodule

// ----- hw/rtl/sled_ctrl.sv -----
module sled_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  sled_pkg::t_dp_stat i_stat,
    output logic               o_rx_stall,
    output sled_pkg::t_dp_cmd  o_cmd
);

    sled_pkg::t_state r_state;
    sled_pkg::t_state n_state;
    logic             parsing;
    logic             accept;

    always_comb begin
        parsing = (r_state inside {sled_pkg::ST_WAIT, sled_pkg::ST_CMD, sled_pkg::ST_LEN,
                                   sled_pkg::ST_DATA, sled_pkg::ST_SUM, sled_pkg::ST_END});
    end

    assign accept = i_rx_valid && parsing && i_stat.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sled_pkg::ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sled_pkg::ST_WAIT: begin
                if (accept) begin
                    if (i_stat.is_start) begin
                        n_state = sled_pkg::ST_CMD;
                    end else if (i_stat.is_lf && !i_stat.is_cr && !i_stat.line_empty) begin
                        n_state = sled_pkg::ST_LIN_RD;
                    end
                end
            end
            sled_pkg::ST_CMD: begin
                if (accept) begin
                    n_state = sled_pkg::ST_LEN;
                end
            end
            sled_pkg::ST_LEN: begin
                if (accept) begin
                    if (i_stat.len_bad) begin
                        n_state = i_stat.is_start ? sled_pkg::ST_CMD : sled_pkg::ST_WAIT;
                    end else if (i_stat.len_zero) begin
                        n_state = sled_pkg::ST_SUM;
                    end else begin
                        n_state = sled_pkg::ST_DATA;
                    end
                end
            end
            sled_pkg::ST_DATA: begin
                if (accept && i_stat.pay_done) begin
                    n_state = sled_pkg::ST_SUM;
                end
            end
            sled_pkg::ST_SUM: begin
                if (accept) begin
                    if (!i_stat.xor_ok) begin
                        n_state = i_stat.is_start ? sled_pkg::ST_CMD : sled_pkg::ST_WAIT;
                    end else begin
                        n_state = sled_pkg::ST_END;
                    end
                end
            end
            sled_pkg::ST_END: begin
                if (accept) begin
                    if (!i_stat.is_end) begin
                        n_state = i_stat.is_start ? sled_pkg::ST_CMD : sled_pkg::ST_WAIT;
                    end else if (i_stat.frame_empty) begin
                        n_state = sled_pkg::ST_WAIT;
                    end else begin
                        n_state = sled_pkg::ST_FRM_RD;
                    end
                end
            end
            sled_pkg::ST_FRM_RD: begin
                n_state = sled_pkg::ST_FRM_WR;
            end
            sled_pkg::ST_FRM_WR: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? sled_pkg::ST_WAIT : sled_pkg::ST_FRM_RD;
                end
            end
            sled_pkg::ST_LIN_RD: begin
                n_state = sled_pkg::ST_LIN_WR;
            end
            sled_pkg::ST_LIN_WR: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? sled_pkg::ST_WAIT : sled_pkg::ST_LIN_RD;
                end
            end
            default: begin
                n_state = sled_pkg::ST_WAIT;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.out_kind = sled_pkg::KIND_FRAME_HDR;
        o_cmd.out_err  = sled_pkg::ERR_LENGTH;
        o_rx_stall     = !(parsing && i_stat.out_free);
        case (r_state)
            sled_pkg::ST_WAIT: begin
                if (accept && !i_stat.is_start && !i_stat.is_cr) begin
                    if (i_stat.is_lf) begin
                        o_cmd.emit_line = 1'b1;
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_kind  = sled_pkg::KIND_LINE_HDR;
                        o_cmd.out_last  = i_stat.line_empty;
                    end else if (!i_stat.line_full) begin
                        o_cmd.line_push = 1'b1;
                    end else begin
                        // drop the whole line and report it
                        o_cmd.line_drop = 1'b1;
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_kind  = sled_pkg::KIND_LINE_OVF;
                        o_cmd.out_last  = 1'b1;
                    end
                end
            end
            sled_pkg::ST_CMD: begin
                o_cmd.store_cmd = accept;
            end
            sled_pkg::ST_LEN: begin
                if (accept) begin
                    if (i_stat.len_bad) begin
                        o_cmd.clear_frame = 1'b1;
                        o_cmd.inc_bad     = 1'b1;
                        o_cmd.out_load    = 1'b1;
                        o_cmd.out_kind    = sled_pkg::KIND_FRAME_ERR;
                        o_cmd.out_err     = sled_pkg::ERR_LENGTH;
                        o_cmd.out_last    = 1'b1;
                    end else begin
                        o_cmd.load_len = 1'b1;
                    end
                end
            end
            sled_pkg::ST_DATA: begin
                o_cmd.take_data = accept;
            end
            sled_pkg::ST_SUM: begin
                if (accept && !i_stat.xor_ok) begin
                    o_cmd.clear_frame = 1'b1;
                    o_cmd.inc_bad     = 1'b1;
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_kind    = sled_pkg::KIND_FRAME_ERR;
                    o_cmd.out_err     = sled_pkg::ERR_CHECKSUM;
                    o_cmd.out_last    = 1'b1;
                end
            end
            sled_pkg::ST_END: begin
                if (accept) begin
                    o_cmd.clear_frame = 1'b1;
                    o_cmd.out_load    = 1'b1;
                    if (!i_stat.is_end) begin
                        o_cmd.inc_bad  = 1'b1;
                        o_cmd.out_kind = sled_pkg::KIND_FRAME_ERR;
                        o_cmd.out_err  = sled_pkg::ERR_END_MARKER;
                        o_cmd.out_last = 1'b1;
                    end else begin
                        // header takes the old frame fields at the same edge they clear
                        o_cmd.inc_good   = 1'b1;
                        o_cmd.emit_frame = 1'b1;
                        o_cmd.out_kind   = sled_pkg::KIND_FRAME_HDR;
                        o_cmd.out_last   = i_stat.frame_empty;
                    end
                end
            end
            sled_pkg::ST_FRM_RD: begin
                o_cmd.read_pay = 1'b1;
            end
            sled_pkg::ST_FRM_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = sled_pkg::KIND_PAYLOAD;
                    o_cmd.out_last  = i_stat.emit_last;
                    o_cmd.emit_step = 1'b1;
                end
            end
            sled_pkg::ST_LIN_RD: begin
                o_cmd.read_line = 1'b1;
            end
            sled_pkg::ST_LIN_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_kind  = sled_pkg::KIND_LINE_CHAR;
                    o_cmd.out_last  = i_stat.emit_last;
                    o_cmd.emit_step = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sled_pkg::ST_FRM_RD || r_state == sled_pkg::ST_FRM_WR ||
         r_state == sled_pkg::ST_LIN_RD || r_state == sled_pkg::ST_LIN_WR) |-> o_rx_stall)
        else $error("input taken during burst emission");

    a_read_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.read_pay || o_cmd.read_line) |=>
        (r_state == sled_pkg::ST_FRM_WR || r_state == sled_pkg::ST_LIN_WR))
        else $error("store read not followed by result load");

    a_single_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.line_push, o_cmd.take_data, o_cmd.store_cmd, o_cmd.load_len}) <= 1)
        else $error("byte routed to more than one destination");

endmodule

// ----- hw/rtl/sof_len_xor_eof_deframer.sv -----
// Frame and text-line deframer for a received serial byte stream.
// Input channel: i_rx_valid / o_rx_stall carry one byte in i_rx_byte.
// Output channel: o_res_valid / i_res_stall carry one result (kind, command,
// length, data byte, error code, last flag and the two frame tallies).
// Frames are start marker, command, length, payload, XOR checksum, end marker;
// outside a frame, bytes build a text line emitted on LF.
// Configuration: i_cfg_we with i_cfg_idx 0 (start marker) or 1 (end marker).
// A byte that ends a frame, a line or a bad frame shows its first result in the
// cycle after it is taken. The header is followed by a burst of N stored bytes; each
// byte is first read from the store and then loaded into the output register, and
// no input is taken during the burst.
// Other bytes are taken at one per cycle while the output register is free
// or being drained in the same cycle.
// Reset (synchronous, active low) returns the parser to waiting for a start
// marker, empties the line, clears tallies and restores the default markers.
// A stalled output holds its result and stalls the input in turn.
module sof_len_xor_eof_deframer #(
    parameter int MAX_PAYLOAD   = sled_pkg::MAX_PAYLOAD_DEF,
    parameter int LINE_CAPACITY = sled_pkg::LINE_CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sled_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sled_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_rx_valid,
    output logic                           o_rx_stall,
    input  logic [sled_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                           o_res_valid,
    input  logic                           i_res_stall,
    output logic [sled_pkg::KIND_W-1:0]    o_kind,
    output logic [sled_pkg::BYTE_W-1:0]    o_command,
    output logic [sled_pkg::LEN_W-1:0]     o_length,
    output logic [sled_pkg::BYTE_W-1:0]    o_data_byte,
    output logic [sled_pkg::ERR_W-1:0]     o_error_code,
    output logic                           o_last,
    output logic [sled_pkg::TALLY_W-1:0]   o_good_frames,
    output logic [sled_pkg::TALLY_W-1:0]   o_bad_frames
);

    sled_pkg::t_dp_cmd  dp_cmd;
    sled_pkg::t_dp_stat dp_stat;

    sled_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_stat     (dp_stat),
        .o_rx_stall (o_rx_stall),
        .o_cmd      (dp_cmd)
    );

    sled_dp #(
        .MAX_PAYLOAD   (MAX_PAYLOAD),
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_rx_byte),
        .i_res_stall   (i_res_stall),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_res_valid   (o_res_valid),
        .o_kind        (o_kind),
        .o_command     (o_command),
        .o_length      (o_length),
        .o_data_byte   (o_data_byte),
        .o_error_code  (o_error_code),
        .o_last        (o_last),
        .o_good_frames (o_good_frames),
        .o_bad_frames  (o_bad_frames)
    );

endmodule

// ----- tb/tb_sof_len_xor_eof_deframer.sv -----
module tb_sof_len_xor_eof_deframer;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PCT      = 29;
    localparam int PHASE_ITEMS   = 36;
    localparam int LINE_MAX      = sled_pkg::LINE_CAPACITY_DEF - 1;

    localparam logic [sled_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = sled_pkg::CFG_IDX_W'(2);
    localparam logic [sled_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = sled_pkg::CFG_IDX_W'(3);

    // error field reads zero outside frame errors
    localparam sled_pkg::t_err ERR_NONE = sled_pkg::ERR_LENGTH;

    typedef enum logic [2:0] {P_WAIT, P_CMD, P_LEN, P_DATA, P_SUM, P_END} t_parse;
    typedef enum int {BREAK_NONE, BREAK_LEN, BREAK_SUM, BREAK_END} t_frame_break;

    typedef struct packed {
        sled_pkg::t_kind kind;
        logic [7:0]      command;
        logic [5:0]      length;
        logic [7:0]      data_byte;
        sled_pkg::t_err  error_code;
        logic            last;
        logic [31:0]     good;
        logic [31:0]     bad;
    } t_deframe_res;

    typedef struct packed {
        logic [7:0]      rx;
        logic            typed;
        logic [5:0]      n;
        sled_pkg::t_kind kind;
        sled_pkg::t_err  code;
    } t_probe_row;

    localparam t_probe_row PROBE_ROWS [28] = '{
        '{8'h0A, 1'b1, 6'd1, sled_pkg::KIND_LINE_HDR,  ERR_NONE},
        '{8'h0D, 1'b1, 6'd0, sled_pkg::KIND_LINE_HDR,  ERR_NONE},
        '{8'h00, 1'b1, 6'd0, sled_pkg::KIND_LINE_HDR,  ERR_NONE},
        '{8'hFF, 1'b1, 6'd0, sled_pkg::KIND_LINE_HDR,  ERR_NONE},
        '{8'h0A, 1'b1, 6'd3, sled_pkg::KIND_LINE_HDR,  ERR_NONE},
        '{8'hAA, 1'b1, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h01, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h21, 1'b1, 6'd1, sled_pkg::KIND_FRAME_ERR, sled_pkg::ERR_LENGTH},
        '{8'hAA, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'hFF, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h00, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'hFF, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h55, 1'b1, 6'd1, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'hAA, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h12, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h02, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h34, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h56, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h00, 1'b1, 6'd1, sled_pkg::KIND_FRAME_ERR, sled_pkg::ERR_CHECKSUM},
        '{8'hAA, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h07, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h00, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h07, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'hAA, 1'b1, 6'd1, sled_pkg::KIND_FRAME_ERR, sled_pkg::ERR_END_MARKER},
        '{8'h03, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h00, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h03, 1'b0, 6'd0, sled_pkg::KIND_FRAME_HDR, ERR_NONE},
        '{8'h55, 1'b1, 6'd1, sled_pkg::KIND_FRAME_HDR, ERR_NONE}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sled_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [sled_pkg::BYTE_W-1:0]    cfg_data;
    logic                           rx_valid;
    logic                           rx_stall;
    logic [sled_pkg::BYTE_W-1:0]    rx_byte;
    logic                           res_valid;
    logic                           res_stall;
    logic [sled_pkg::KIND_W-1:0]    res_kind;
    logic [sled_pkg::BYTE_W-1:0]    res_command;
    logic [sled_pkg::LEN_W-1:0]     res_length;
    logic [sled_pkg::BYTE_W-1:0]    res_data;
    logic [sled_pkg::ERR_W-1:0]     res_code;
    logic                           res_last;
    logic [sled_pkg::TALLY_W-1:0]   res_good;
    logic [sled_pkg::TALLY_W-1:0]   res_bad;

    // parser shadow
    t_parse      parser_at = P_WAIT;
    logic [7:0]  mk_start  = sled_pkg::START_MARKER_RST;
    logic [7:0]  mk_end    = sled_pkg::END_MARKER_RST;
    logic [7:0]  cur_cmd   = '0;
    int          cur_len   = 0;
    int          pay_idx   = 0;
    logic [7:0]  sum_acc   = '0;
    logic [7:0]  pay_buf [sled_pkg::MAX_PAYLOAD_DEF];
    logic [7:0]  line_buf [LINE_MAX];
    int          line_cnt  = 0;
    logic [31:0] good_cnt  = '0;
    logic [31:0] bad_cnt   = '0;

    t_deframe_res pending_results[$];

    int mismatches   = 0;
    int rx_count     = 0;
    int step_results = 0;
    int cycle_count  = 0;
    bit calm         = 1'b0;

    sof_len_xor_eof_deframer u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_rx_valid    (rx_valid),
        .o_rx_stall    (rx_stall),
        .i_rx_byte     (rx_byte),
        .o_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .o_kind        (res_kind),
        .o_command     (res_command),
        .o_length      (res_length),
        .o_data_byte   (res_data),
        .o_error_code  (res_code),
        .o_last        (res_last),
        .o_good_frames (res_good),
        .o_bad_frames  (res_bad)
    );

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic void expect_res(sled_pkg::t_kind k, logic [7:0] c, logic [5:0] l,
                                       logic [7:0] d, sled_pkg::t_err e);
        t_deframe_res r;
        r.kind       = k;
        r.command    = c;
        r.length     = l;
        r.data_byte  = d;
        r.error_code = e;
        r.last       = 1'b0;
        r.good       = good_cnt;
        r.bad        = bad_cnt;
        pending_results.push_back(r);
    endfunction

    function automatic void frame_clear();
        cur_cmd = '0;
        cur_len = 0;
        pay_idx = 0;
        sum_acc = '0;
    endfunction

    function automatic int frame_bad(logic [7:0] b, sled_pkg::t_err code);
        bad_cnt++;
        frame_clear();
        // resync straight to the command byte when the bad byte opens a frame
        parser_at = (b == mk_start) ? P_CMD : P_WAIT;
        expect_res(sled_pkg::KIND_FRAME_ERR, '0, '0, '0, code);
        return 1;
    endfunction

    function automatic int line_take(logic [7:0] b);
        int i;
        int n;
        if (b == sled_pkg::CHAR_CR) return 0;
        if (b == sled_pkg::CHAR_LF) begin
            expect_res(sled_pkg::KIND_LINE_HDR, '0, 6'(line_cnt), '0, ERR_NONE);
            for (i = 0; i < line_cnt; i++)
                expect_res(sled_pkg::KIND_LINE_CHAR, '0, '0, line_buf[i], ERR_NONE);
            n = line_cnt + 1;
            line_cnt = 0;
            return n;
        end
        if (line_cnt < LINE_MAX) begin
            line_buf[line_cnt] = b;
            line_cnt++;
            return 0;
        end
        line_cnt = 0;
        expect_res(sled_pkg::KIND_LINE_OVF, '0, '0, '0, ERR_NONE);
        return 1;
    endfunction

    function automatic int deframe_step(logic [7:0] b);
        int n;
        int i;
        t_deframe_res tail;
        n = 0;
        case (parser_at)
            P_WAIT: begin
                // start marker wins over CR and LF
                if (b == mk_start) parser_at = P_CMD;
                else n = line_take(b);
            end
            P_CMD: begin
                cur_cmd = b;
                parser_at = P_LEN;
            end
            P_LEN: begin
                if (b > sled_pkg::MAX_PAYLOAD_DEF) begin
                    n = frame_bad(b, sled_pkg::ERR_LENGTH);
                end else begin
                    cur_len = b;
                    pay_idx = 0;
                    sum_acc = cur_cmd ^ b;
                    parser_at = (b == 8'd0) ? P_SUM : P_DATA;
                end
            end
            P_DATA: begin
                if (pay_idx < sled_pkg::MAX_PAYLOAD_DEF) pay_buf[pay_idx] = b;
                sum_acc ^= b;
                pay_idx++;
                if (pay_idx >= cur_len) parser_at = P_SUM;
            end
            P_SUM: begin
                if (b != sum_acc) n = frame_bad(b, sled_pkg::ERR_CHECKSUM);
                else parser_at = P_END;
            end
            P_END: begin
                if (b != mk_end) begin
                    n = frame_bad(b, sled_pkg::ERR_END_MARKER);
                end else begin
                    good_cnt++;
                    expect_res(sled_pkg::KIND_FRAME_HDR, cur_cmd, 6'(cur_len), sum_acc,
                               ERR_NONE);
                    for (i = 0; i < cur_len; i++)
                        expect_res(sled_pkg::KIND_PAYLOAD, '0, '0, pay_buf[i], ERR_NONE);
                    n = cur_len + 1;
                    frame_clear();
                    parser_at = P_WAIT;
                end
            end
            default: begin
                frame_clear();
                parser_at = P_WAIT;
            end
        endcase
        if (n > 0) begin
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
        end
        return n;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic logic [7:0] off_byte(logic [7:0] good_val);
        logic [7:0] v;
        if ($urandom_range(1) == 0 && mk_start != good_val) return mk_start;
        do v = 8'($urandom); while (v == good_val);
        return v;
    endfunction

    function automatic logic [7:0] line_char();
        logic [7:0] c;
        do c = 8'($urandom);
        while (c == mk_start || c == sled_pkg::CHAR_CR || c == sled_pkg::CHAR_LF);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (idle_now()) begin
            rx_valid = 1'b0;
            @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        step_results = deframe_step(b);
        rx_count++;
    endtask

    task automatic send_frame();
        int len;
        int r;
        t_frame_break brk;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] v;
        r = $urandom_range(9);
        if (r == 0) len = 0;
        else if (r == 1) len = sled_pkg::MAX_PAYLOAD_DEF;
        else if (r == 2) len = $urandom_range(9, sled_pkg::MAX_PAYLOAD_DEF - 1);
        else len = $urandom_range(1, 8);
        r = $urandom_range(9);
        brk = (r < 7) ? BREAK_NONE : t_frame_break'(r - 6);
        cmd = 8'($urandom);
        // after a resync the parser already waits for the command byte
        if (parser_at != P_CMD) send_byte(mk_start);
        send_byte(cmd);
        if (brk == BREAK_LEN) begin
            if ($urandom_range(1) == 0 && mk_start > sled_pkg::MAX_PAYLOAD_DEF) v = mk_start;
            else v = 8'($urandom_range(sled_pkg::MAX_PAYLOAD_DEF + 1, 255));
            send_byte(v);
            return;
        end
        send_byte(8'(len));
        sum = cmd ^ 8'(len);
        repeat (len) begin
            v = 8'($urandom);
            sum ^= v;
            send_byte(v);
        end
        if (brk == BREAK_SUM) begin
            send_byte(off_byte(sum));
            return;
        end
        send_byte(sum);
        send_byte((brk == BREAK_END) ? off_byte(mk_end) : mk_end);
    endtask

    task automatic send_line();
        int n;
        if ($urandom_range(99) < 15) n = $urandom_range(LINE_MAX - 1, LINE_MAX + 4);
        else n = $urandom_range(0, 12);
        repeat (n) begin
            if ($urandom_range(9) == 0) send_byte(sled_pkg::CHAR_CR);
            send_byte(line_char());
        end
        send_byte(sled_pkg::CHAR_LF);
    endtask

    task automatic run_phase();
        int target;
        int r;
        target = rx_count + PHASE_ITEMS;
        while (rx_count < target) begin
            r = $urandom_range(99);
            if (r < 50) send_frame();
            else if (r < 85) send_line();
            else repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
    endtask

    // hold the input low until every pending result is out and the block is quiet
    task automatic drain();
        @(negedge clk);
        rx_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [sled_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        if (idx == sled_pkg::CFG_START_MARKER) mk_start = val;
        else if (idx == sled_pkg::CFG_END_MARKER) mk_end = val;
    endtask

    task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
        drain();
        cfg_write(sled_pkg::CFG_START_MARKER, s);
        cfg_write(sled_pkg::CFG_END_MARKER, e);
        cfg_write(CFG_UNUSED_A, 8'($urandom));
        cfg_write(CFG_UNUSED_B, 8'($urandom));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            res_stall = idle_now();
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL sof_len_xor_eof_deframer");
            $finish;
        end
    end

    always @(posedge clk) begin : res_check
        t_deframe_res got;
        t_deframe_res want;
        if (rst_n && res_valid && !res_stall) begin
            got.kind       = sled_pkg::t_kind'(res_kind);
            got.command    = res_command;
            got.length     = res_length;
            got.data_byte  = res_data;
            got.error_code = sled_pkg::t_err'(res_code);
            got.last       = res_last;
            got.good       = res_good;
            got.bad        = res_bad;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind=%0d data=%02h",
                                        res_kind, res_data));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    flag_mismatch({
                        $sformatf("got k%0d c%02h l%0d d%02h e%0d z%0b g%0d b%0d",
                                  got.kind, got.command, got.length, got.data_byte,
                                  got.error_code, got.last, got.good, got.bad),
                        $sformatf(", want k%0d c%02h l%0d d%02h e%0d z%0b g%0d b%0d",
                                  want.kind, want.command, want.length, want.data_byte,
                                  want.error_code, want.last, want.good, want.bad)});
            end
        end
    end

    initial begin
        int i;
        t_probe_row row;
        t_deframe_res first;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = sled_pkg::CFG_START_MARKER;
        cfg_data = '0;
        rx_valid = 1'b0;
        rx_byte  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < $size(PROBE_ROWS); i++) begin
            row = PROBE_ROWS[i];
            send_byte(row.rx);
            if (row.typed) begin
                if (step_results != int'(row.n)) begin
                    flag_mismatch($sformatf("request %0d: %0d results predicted, %0d listed",
                                            i, step_results, row.n));
                end else if (row.n != 0 && pending_results.size() >= step_results) begin
                    first = pending_results[pending_results.size() - step_results];
                    if (first.kind != row.kind || first.error_code != row.code)
                        flag_mismatch($sformatf("request %0d: predicted kind %0d code %0d",
                                                i, first.kind, first.error_code));
                end
            end
        end

        run_phase();
        set_markers(sled_pkg::CHAR_LF, sled_pkg::CHAR_CR);
        run_phase();
        calm = 1'b1;
        set_markers(8'h00, 8'hFF);
        run_phase();
        calm = 1'b0;
        set_markers(8'hFF, 8'h00);
        run_phase();
        set_markers(8'h5A, 8'h5A);
        run_phase();
        set_markers(8'($urandom), 8'($urandom));
        run_phase();

        drain();
        if (mismatches == 0) begin
            $display("PASS sof_len_xor_eof_deframer");
        end else begin
            $display("FAIL sof_len_xor_eof_deframer");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sled_pkg.sv
hw/rtl/sled_ram.sv
hw/rtl/sled_dp.sv
hw/rtl/sled_ctrl.sv
hw/rtl/sof_len_xor_eof_deframer.sv
tb/tb_sof_len_xor_eof_deframer.sv
